FILE: hw/rtl/rro_pkg.sv
// Package for the rounded rectangle outline generator: job record and
// elaboration-time helpers for the arc normal tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rro_pkg;

    localparam int CORNERS   = 4;
    localparam int CENTRE_W  = 18;
    localparam int RADIUS_W  = 15;
    localparam int SEG_W     = 4;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [CORNERS-1:0][CENTRE_W-1:0] cx;
        logic signed [CORNERS-1:0][CENTRE_W-1:0] cy;
        logic [CORNERS-1:0][RADIUS_W-1:0]        r;
    } job_t;

    // Shift-subtract division, used only while building constant tables.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arc angle for point j of s segments in Q2.30, rounded half up.
    function automatic longint unsigned theta_q30(input int j, input int s);
        return udiv64(HALF_PI_Q30 * longint'(j) * 64'd2 + longint'(s), 64'(2 * s));
    endfunction

    // Taylor series in Q2.30 (cosine, or sine when odd is set), clamped to
    // [0, 1] and rounded half up to nf fraction bits.
    function automatic longint unsigned trig_fix(input longint unsigned x,
                                                 input logic odd, input int nf);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned a;
        x2   = (x * x) >> 30;
        term = odd ? x : (64'd1 << 30);
        sum  = longint'(term);
        for (int k = 1; k <= 8; k++) begin
            a    = odd ? 64'(2 * k) : 64'(2 * k - 1);
            term = udiv64((term * x2) >> 30, a * (a + 64'd1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        return (longint'(sum) + (64'd1 << (29 - nf))) >> (30 - nf);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rro_front.sv
// Front end: clamps the four corner radii of a rectangle and works out the
// arc centres in walk order. Depends on rro_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rro_front (
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic [14:0]        rect_width,
    input  wire logic [14:0]        rect_height,
    input  wire logic signed [15:0] radius_top_left,
    input  wire logic signed [15:0] radius_top_right,
    input  wire logic signed [15:0] radius_bottom_right,
    input  wire logic signed [15:0] radius_bottom_left,
    output rro_pkg::job_t           job
);
    import rro_pkg::*;

    logic [14:0]                limit;
    logic signed [15:0]         req [CORNERS];
    logic [RADIUS_W-1:0]        rc  [CORNERS];
    logic signed [CENTRE_W-1:0] x_e, y_e, w_e, h_e;

    assign limit = ((rect_width < rect_height) ? rect_width : rect_height) >> 1;

    assign req[0] = radius_top_right;
    assign req[1] = radius_bottom_right;
    assign req[2] = radius_bottom_left;
    assign req[3] = radius_top_left;

    always_comb
    begin
        for (int c = 0; c < CORNERS; c++)
        begin
            if (req[c][15]) begin
                rc[c] = '0;
            end else if (req[c][14:0] > limit) begin
                rc[c] = limit;
            end else begin
                rc[c] = req[c][14:0];
            end
        end
    end

    assign x_e = CENTRE_W'(rect_x);
    assign y_e = CENTRE_W'(rect_y);
    assign w_e = signed'({3'b000, rect_width});
    assign h_e = signed'({3'b000, rect_height});

    always_comb
    begin
        for (int c = 0; c < CORNERS; c++)
        begin
            job.r[c] = rc[c];
        end
        job.cx[0] = x_e + w_e - signed'({3'b000, rc[0]});
        job.cy[0] = y_e + signed'({3'b000, rc[0]});
        job.cx[1] = x_e + w_e - signed'({3'b000, rc[1]});
        job.cy[1] = y_e + h_e - signed'({3'b000, rc[1]});
        job.cx[2] = x_e + signed'({3'b000, rc[2]});
        job.cy[2] = y_e + h_e - signed'({3'b000, rc[2]});
        job.cx[3] = x_e + signed'({3'b000, rc[3]});
        job.cy[3] = y_e + signed'({3'b000, rc[3]});
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rro_queue.sv
// Two-entry job queue between the front end and the point walker.
// Depends on rro_pkg for the job record.
`timescale 1ns / 1ps
`default_nettype none

module rro_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire rro_pkg::job_t wr_job,
    output logic               q_full,
    input  wire logic          rd_en,
    output rro_pkg::job_t      rd_job,
    output logic               q_empty
);
    import rro_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_job  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rro_back.sv
// Point walker: steps through the corners and arc points of one job, looks
// up the normal, scales it by the radius and saturates the point. Uses rro_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rro_back #(
    parameter int MAX_SEGMENTS     = 15,
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [3:0]         arc_segments,
    input  wire rro_pkg::job_t      q_job,
    input  wire logic               q_empty,
    output logic                    q_rd,
    output logic signed [15:0]      point_x,
    output logic signed [15:0]      point_y,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic                    last_point,
    output logic                    empty,
    input  wire logic               pop
);
    import rro_pkg::*;

    localparam int NF    = NORMAL_FRAC_BITS;
    localparam int TV_W  = NF + 1;
    localparam int NRM_W = NF + 2;
    localparam int PW    = RADIUS_W + 1 + NRM_W;
    localparam int SW    = 34;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic [PW-1:0] HALF = PW'(64'd1 << (NF - 1));

    function automatic logic [256*TV_W-1:0] build_tab(input logic odd);
        logic [256*TV_W-1:0] tab;
        longint unsigned     v;
        tab = '0;
        for (int s = 1; s < 16; s++) begin
            for (int j = 0; j <= s; j++) begin
                v = trig_fix(theta_q30(j, s), odd, NF);
                tab[(s * 16 + j) * TV_W +: TV_W] = v[TV_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam logic [256*TV_W-1:0] COS_TAB = build_tab(1'b0);
    localparam logic [256*TV_W-1:0] SIN_TAB = build_tab(1'b1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    job_t       job_reg;
    logic [1:0] corner_reg, corner_next;
    logic [3:0] seg_reg, seg_next;
    logic [3:0] segs_reg;
    logic [3:0] segs_eff;

    logic signed [PW-1:0]       px_reg, py_reg;
    logic signed [NRM_W-1:0]    nx_reg, ny_reg;
    logic signed [CENTRE_W-1:0] cx_reg, cy_reg;
    logic                       last_reg;
    logic                       out_valid_reg, out_valid_next;

    logic [7:0]              tab_idx;
    logic signed [NRM_W-1:0] cs, sn, nx, ny;
    logic signed [RADIUS_W:0] r_s;
    logic                    out_load;
    logic signed [SW-1:0]    sum_x, sum_y;

    always_comb
    begin
        if (arc_segments == 4'd0) begin
            segs_eff = 4'd1;
        end else if (32'(arc_segments) > MAX_SEGMENTS) begin
            segs_eff = 4'(MAX_SEGMENTS);
        end else begin
            segs_eff = arc_segments;
        end
    end

    assign tab_idx = {segs_reg, seg_reg};
    assign cs  = signed'({1'b0, COS_TAB[tab_idx * TV_W +: TV_W]});
    assign sn  = signed'({1'b0, SIN_TAB[tab_idx * TV_W +: TV_W]});
    assign r_s = signed'({1'b0, job_reg.r[corner_reg]});

    always_comb
    begin
        case (corner_reg)
            2'd0:    begin nx = sn;  ny = -cs; end
            2'd1:    begin nx = cs;  ny = sn;  end
            2'd2:    begin nx = -sn; ny = cs;  end
            default: begin nx = -cs; ny = -sn; end
        endcase
    end

    // Round the scaled offset to the coordinate grid, halves away from zero.
    function automatic logic signed [SW-1:0] round_off(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q   = (mag + HALF) >> NF;
        return p[PW-1] ? -SW'(q) : SW'(q);
    endfunction

    function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        if (v > SAT_HI) begin
            t = SAT_HI;
        end else if (v < SAT_LO) begin
            t = SAT_LO;
        end else begin
            t = v;
        end
        return t[15:0];
    endfunction

    assign sum_x = SW'(cx_reg) + round_off(px_reg);
    assign sum_y = SW'(cy_reg) + round_off(py_reg);

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || pop);
    assign q_rd     = (state_reg == ST_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty) begin
                    corner_next = 2'd0;
                    seg_next    = 4'd0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_MUL;
                    if (seg_reg == segs_reg) begin
                        seg_next = 4'd0;
                        if (corner_reg == 2'd3) begin
                            corner_next = 2'd0;
                            state_next  = ST_IDLE;
                        end else begin
                            corner_next = corner_reg + 2'd1;
                        end
                    end else begin
                        seg_next = seg_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_rd) begin
            job_reg  <= q_job;
            segs_reg <= segs_eff;
        end
        if (state_reg == ST_MUL) begin
            // Both factors are sign-extended to the full product width.
            px_reg   <= r_s * nx;
            py_reg   <= r_s * ny;
            nx_reg   <= nx;
            ny_reg   <= ny;
            cx_reg   <= job_reg.cx[corner_reg];
            cy_reg   <= job_reg.cy[corner_reg];
            last_reg <= (corner_reg == 2'd3) && (seg_reg == segs_reg);
        end
        if (out_load) begin
            point_x    <= sat16(sum_x);
            point_y    <= sat16(sum_y);
            normal_x   <= 16'(nx_reg);
            normal_y   <= 16'(ny_reg);
            last_point <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            corner_reg    <= 2'd0;
            seg_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rounded_rect_outline_generator.sv
// Rounded rectangle outline generator. The point walker handles one point at a
// time, first a table read and multiply, then a round and saturate, and it holds
// in the round and saturate step while the previous point still waits for pop; a
// two-entry job queue lets further rectangles be pushed meanwhile. Reset (rst_n,
// async, active low) empties the queue and the output and sets arc_segments to 8.
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_outline_generator #(
    parameter int MAX_SEGMENTS     = 15,
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic [14:0]        rect_width,
    input  wire logic [14:0]        rect_height,
    input  wire logic signed [15:0] radius_top_left,
    input  wire logic signed [15:0] radius_top_right,
    input  wire logic signed [15:0] radius_bottom_right,
    input  wire logic signed [15:0] radius_bottom_left,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      point_x,
    output logic signed [15:0]      point_y,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic                    last_point
);
    import rro_pkg::*;

    logic [3:0] arc_segments_reg;
    job_t       front_job, q_job;
    logic       q_full, q_empty, q_rd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            arc_segments_reg <= 4'd8;
        end else if (cfg_valid) begin
            arc_segments_reg <= cfg_data;
        end
    end

    rro_front u_front (
        .rect_x              (rect_x),
        .rect_y              (rect_y),
        .rect_width          (rect_width),
        .rect_height         (rect_height),
        .radius_top_left     (radius_top_left),
        .radius_top_right    (radius_top_right),
        .radius_bottom_right (radius_bottom_right),
        .radius_bottom_left  (radius_bottom_left),
        .job                 (front_job)
    );

    rro_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !q_full),
        .wr_job  (front_job),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_job  (q_job),
        .q_empty (q_empty)
    );

    rro_back #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .arc_segments (arc_segments_reg),
        .q_job        (q_job),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .point_x      (point_x),
        .point_y      (point_y),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .last_point   (last_point),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

`default_nettype wire
